### hw/rtl/u8u16_pkg.sv
// Package for the UTF-8 to UTF-16 (BMP) decoder: word types, the queue entry
// type, the pending-sequence state encoding and the byte constants.
// Depends on nothing; every other file of the decoder imports it.
`default_nettype none

package u8u16_pkg;

   // One input word: a raw UTF-8 byte and the end-of-string flag.
   typedef struct packed {
      logic [7:0] byte_value;
      logic       final_byte;
   } u8u16_req_type;

   // One result word: a UTF-16 code unit, and the flag set on the terminator.
   typedef struct packed {
      logic [15:0] code_unit;
      logic        end_of_run;
   } u8u16_rsp_type;

   localparam int unsigned MaxUnits = 3;

   // What one input byte produces, as handed from the front to the back.
   typedef struct packed {
      logic [1:0]                    unit_count;
      logic                          with_term;
      logic [MaxUnits-1:0][15:0]     units;
   } u8u16_entry_type;

   // Pending multi-byte sequence state.
   typedef enum logic [2:0] {
      PEND_NONE   = 3'b001,
      PEND_LEAD   = 3'b010,
      PEND_SECOND = 3'b100
   } u8u16_pend_type;

   localparam logic [7:0]  ASCII_LIMIT = 8'h80;
   localparam logic [7:0]  LEAD2_MASK  = 8'hE0;
   localparam logic [7:0]  LEAD2_CODE  = 8'hC0;
   localparam logic [7:0]  LEAD3_MASK  = 8'hF0;
   localparam logic [7:0]  LEAD3_CODE  = 8'hE0;
   localparam logic [15:0] UNIT_QMARK  = 16'h003F;
   localparam logic [15:0] UNIT_TERM   = 16'h0000;

endpackage

`default_nettype wire

### hw/rtl/u8u16_front.sv
// Front end of the decoder: accepts bytes, tracks a pending lead sequence and
// turns each byte into a queue entry of zero to three code units.
// Depends on u8u16_pkg.
`default_nettype none

module u8u16_front
   import u8u16_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            accept,
   input  wire u8u16_req_type   req_data,
   output      logic            enq_valid,
   output      u8u16_entry_type enq_entry
);

   u8u16_pend_type pend_ff, pend_in;
   logic [7:0]     lead_ff, lead_in;
   logic [7:0]     second_ff, second_in;

   logic [7:0]  b;
   logic        fin;
   logic        b_lead2, b_lead3, held_lead2;
   logic [15:0] alone_unit;
   logic [15:0] cp2, cp3;
   logic [1:0]  n;

   assign b          = req_data.byte_value;
   assign fin        = req_data.final_byte;
   assign b_lead2    = (b & LEAD2_MASK) == LEAD2_CODE;
   assign b_lead3    = (b & LEAD3_MASK) == LEAD3_CODE;
   assign held_lead2 = (lead_ff & LEAD2_MASK) == LEAD2_CODE;
   assign alone_unit = (b < ASCII_LIMIT) ? {8'h00, b} : UNIT_QMARK;
   assign cp2        = {5'b00000, lead_ff[4:0], b[5:0]};
   assign cp3        = {lead_ff[3:0], second_ff[5:0], b[5:0]};

   always_comb begin
      pend_in   = pend_ff;
      lead_in   = lead_ff;
      second_in = second_ff;
      n         = 2'd0;
      enq_entry = '0;
      case (pend_ff)
         PEND_LEAD: begin
            if (held_lead2) begin
               enq_entry.units[0] = cp2;
               n       = 2'd1;
               pend_in = PEND_NONE;
            end else if (fin) begin
               // A three-byte lead cut short: the lead and this byte stand alone.
               enq_entry.units[0] = UNIT_QMARK;
               enq_entry.units[1] = alone_unit;
               n       = 2'd2;
               pend_in = PEND_NONE;
            end else begin
               second_in = b;
               pend_in   = PEND_SECOND;
            end
         end
         PEND_SECOND: begin
            enq_entry.units[0] = cp3;
            n       = 2'd1;
            pend_in = PEND_NONE;
         end
         default: begin
            if (b < ASCII_LIMIT) begin
               enq_entry.units[0] = {8'h00, b};
               n = 2'd1;
            end else if (!fin && (b_lead2 || b_lead3)) begin
               lead_in = b;
               pend_in = PEND_LEAD;
            end else begin
               enq_entry.units[0] = UNIT_QMARK;
               n = 2'd1;
            end
         end
      endcase
      if (fin) begin
         enq_entry.units[n]  = UNIT_TERM;
         enq_entry.with_term = 1'b1;
         n       = n + 2'd1;
         pend_in = PEND_NONE;
      end
      enq_entry.unit_count = n;
   end

   assign enq_valid = accept && (n != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= PEND_NONE;
      end else if (accept) begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         lead_ff   <= lead_in;
         second_ff <= second_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/u8u16_queue.sv
// Short register queue that holds decoded entries between the front and back.
// Depends on u8u16_pkg for the entry type.
`default_nettype none

module u8u16_queue
   import u8u16_pkg::*;
#(
   parameter int unsigned DEPTH = 4
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            enq_valid,
   input  wire u8u16_entry_type enq_entry,
   output      logic            full,
   output      logic            deq_valid,
   output      u8u16_entry_type deq_entry,
   input  wire logic            deq_pop
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   u8u16_entry_type slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_enq, do_deq;

   assign full      = fill_ff == CNT_W'(DEPTH);
   assign deq_valid = fill_ff != '0;
   assign deq_entry = slots_ff[rd_ptr_ff];
   assign do_enq    = enq_valid && !full;
   assign do_deq    = deq_pop && deq_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_enq) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_deq) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_enq && !do_deq) begin
         fill_in = fill_ff + 1'b1;
      end else if (!do_enq && do_deq) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_enq) begin
         slots_ff[wr_ptr_ff] <= enq_entry;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/u8u16_back.sv
// Back end of the decoder: walks the code units of the head queue entry and
// presents them one word at a time on the result channel.
// Depends on u8u16_pkg.
`default_nettype none

module u8u16_back
   import u8u16_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            deq_valid,
   input  wire u8u16_entry_type deq_entry,
   output      logic            deq_pop,
   output      logic            rsp_empty,
   input  wire logic            rsp_pop,
   output      u8u16_rsp_type   rsp_data
);

   logic [1:0] idx_ff, idx_in;
   logic       last_unit;
   logic       take;

   assign last_unit = idx_ff == (deq_entry.unit_count - 2'd1);
   assign take      = rsp_pop && deq_valid;
   assign deq_pop   = take && last_unit;
   assign rsp_empty = !deq_valid;

   assign rsp_data.code_unit  = deq_entry.units[idx_ff];
   assign rsp_data.end_of_run = deq_entry.with_term && last_unit;

   always_comb begin
      idx_in = idx_ff;
      if (take) begin
         idx_in = last_unit ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/utf8_to_utf16_bmp_decoder_core.sv
// Top level of the UTF-8 to UTF-16 (BMP only) decoder.
// Depends on u8u16_pkg, u8u16_front, u8u16_queue and u8u16_back.
//
// Usage: a UTF-8 string enters one byte per word on the request queue port
// (req_push, req_full, req_data), with final_byte set on its last byte. Each
// word is accepted at a clock edge where req_push is high and req_full is low.
// Decoded UTF-16 code units leave on the response queue port (rsp_empty,
// rsp_pop, rsp_data); the oldest unit is shown while rsp_empty is low and is
// taken at an edge where rsp_pop is high. After the units of the final byte a
// zero terminator word follows with end_of_run set.
// Throughput: one byte per cycle while req_full is low, and one result word
// per cycle while words are waiting. A byte yields zero or one word, a final
// byte two or three; the result side emits one word per cycle while rsp_pop
// is high, so the extra words of a final byte come out one after another,
// while the entry queue lets input continue meanwhile.
// When the receiver stalls, entries collect in the QUEUE_DEPTH-entry queue and
// req_full rises once it is full. Synchronous reset empties the queue and
// drops any partially received multi-byte sequence.
`default_nettype none

module utf8_to_utf16_bmp_decoder_core
   import u8u16_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_push,
   output      logic          req_full,
   input  wire u8u16_req_type req_data,
   output      logic          rsp_empty,
   input  wire logic          rsp_pop,
   output      u8u16_rsp_type rsp_data
);

   logic            accept;
   logic            enq_valid;
   u8u16_entry_type enq_entry;
   logic            deq_valid;
   u8u16_entry_type deq_entry;
   logic            deq_pop;

   // A byte is taken whenever the queue has a free slot, so the front never
   // waits on the result side directly.
   assign accept = req_push && !req_full;

   u8u16_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .enq_valid (enq_valid),
      .enq_entry (enq_entry)
   );

   u8u16_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .enq_valid (enq_valid),
      .enq_entry (enq_entry),
      .full      (req_full),
      .deq_valid (deq_valid),
      .deq_entry (deq_entry),
      .deq_pop   (deq_pop)
   );

   u8u16_back u_back (
      .clock     (clock),
      .reset     (reset),
      .deq_valid (deq_valid),
      .deq_entry (deq_entry),
      .deq_pop   (deq_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### hw/rtl/u8u16_checker.sv
// Port-level checker for the UTF-8 to UTF-16 decoder, bound to its top level.
// Depends on u8u16_pkg and utf8_to_utf16_bmp_decoder_core.
`default_nettype none

module u8u16_checker
   import u8u16_pkg::*;
(
   input wire logic          clock,
   input wire logic          reset,
   input wire logic          req_full,
   input wire logic          rsp_empty,
   input wire logic          rsp_pop,
   input wire u8u16_rsp_type rsp_data
);

   // Reset leaves no word pending on the result side.
   assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result word present right after reset");

   // Reset leaves room for input.
   assert property (@(posedge clock) reset |=> !req_full)
      else $error("input full right after reset");

   // The terminator word always carries a zero code unit.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.end_of_run) |-> (rsp_data.code_unit == UNIT_TERM))
      else $error("end of run on a nonzero code unit");

   // A waiting result word holds until it is popped.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("stalled result word changed");

endmodule

bind utf8_to_utf16_bmp_decoder_core u8u16_checker u_checker (.*);

`default_nettype wire

### test/testbench.sv
// Self-checking testbench for utf8_to_utf16_bmp_decoder_core: directed strings,
// then random strings under several sender and receiver idling patterns.
// Depends on u8u16_pkg and the decoder RTL only.
`default_nettype none

module testbench
   import u8u16_pkg::*;
();

   // One row of the directed stimulus. When typed is set, n code units are
   // given by hand in u0..u2; otherwise the predictor supplies them.
   typedef struct packed {
      logic [7:0]  byte_value;
      logic        last;
      logic        typed;
      logic [1:0]  n;
      logic [15:0] u0;
      logic [15:0] u1;
      logic [15:0] u2;
   } dir_row_type;

   localparam int NUM_DIR_ROWS = 27;
   localparam int PHASE_WORDS  = 50;
   localparam int END_SETTLE   = 10;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_push = 1'b0;
   logic          req_full;
   u8u16_req_type req_data = '0;
   logic          rsp_empty;
   logic          rsp_pop = 1'b0;
   u8u16_rsp_type rsp_data;

   utf8_to_utf16_bmp_decoder_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Predictor state: the held lead byte, the held second byte of a three-byte
   // sequence, and how much of a sequence is held.
   logic [7:0]     held_lead = '0;
   logic [7:0]     held_second = '0;
   u8u16_pend_type held_state = PEND_NONE;

   // Units the predictor derived from the most recent byte, and every unit
   // still owed by the decoder, oldest first.
   u8u16_rsp_type  fresh_units[$];
   u8u16_rsp_type  units_due[$];

   int             error_count = 0;
   int             words_sent = 0;
   int             strings_sent = 0;
   int             units_checked = 0;
   int             idle_pct = 0;
   int             stall_pct = 0;

   dir_row_type    dir_rows [NUM_DIR_ROWS];
   logic [7:0]     str_bytes[$];

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("MISMATCH at %0t: %s got 0x%04h expected 0x%04h", $time, what, got, want);
      error_count++;
   endtask

   function automatic u8u16_rsp_type unit_of(input logic [15:0] unit, input logic eor);
      u8u16_rsp_type r;
      r.code_unit = unit;
      r.end_of_run = eor;
      return r;
   endfunction

   // A byte decoded on its own, as the tail of a string: itself when it is
   // plain ASCII, a question mark otherwise.
   function automatic logic [15:0] lone_unit(input logic [7:0] b);
      return (b < ASCII_LIMIT) ? {8'h00, b} : UNIT_QMARK;
   endfunction

   // Works out the code units that one input word produces and advances the
   // held-sequence state, leaving the units in fresh_units.
   function automatic void decode_word(input u8u16_req_type w);
      logic [7:0] b;
      logic       fin;
      logic       lead2;
      logic       lead3;
      logic       held2;
      logic       held3;
      b = w.byte_value;
      fin = w.final_byte;
      lead2 = (b & LEAD2_MASK) == LEAD2_CODE;
      lead3 = (b & LEAD3_MASK) == LEAD3_CODE;
      held2 = (held_lead & LEAD2_MASK) == LEAD2_CODE;
      held3 = (held_lead & LEAD3_MASK) == LEAD3_CODE;
      fresh_units.delete();
      if (held_state == PEND_LEAD && held2) begin
         fresh_units.insert(fresh_units.size(),
                            unit_of({5'd0, held_lead[4:0], b[5:0]}, 1'b0));
         held_state = PEND_NONE;
      end else if (held_state == PEND_LEAD && held3) begin
         if (fin) begin
            // The string ends inside a three-byte sequence.
            fresh_units.insert(fresh_units.size(), unit_of(UNIT_QMARK, 1'b0));
            fresh_units.insert(fresh_units.size(), unit_of(lone_unit(b), 1'b0));
            held_state = PEND_NONE;
         end else begin
            held_second = b;
            held_state = PEND_SECOND;
         end
      end else if (held_state == PEND_SECOND) begin
         fresh_units.insert(fresh_units.size(),
            unit_of({held_lead[3:0], held_second[5:0], b[5:0]}, 1'b0));
         held_state = PEND_NONE;
      end else begin
         if (b < ASCII_LIMIT) begin
            fresh_units.insert(fresh_units.size(), unit_of({8'h00, b}, 1'b0));
         end else if (!fin && (lead2 || lead3)) begin
            held_lead = b;
            held_state = PEND_LEAD;
         end else begin
            fresh_units.insert(fresh_units.size(), unit_of(UNIT_QMARK, 1'b0));
         end
      end
      if (fin) begin
         fresh_units.insert(fresh_units.size(), unit_of(UNIT_TERM, 1'b1));
         held_lead = '0;
         held_second = '0;
         held_state = PEND_NONE;
      end
   endfunction

   // Offers one word after a random idle stretch, holds it until the decoder
   // takes it. If the stretch is empty, push stays high from one word to the
   // next, so only the data changes at the edge that accepts the previous word.
   task automatic send_word(input logic [7:0] b, input logic last, input logic typed,
                            input logic [1:0] n, input logic [15:0] u0,
                            input logic [15:0] u1, input logic [15:0] u2);
      u8u16_req_type w;
      logic [15:0]   hand[3];
      w.byte_value = b;
      w.final_byte = last;
      hand[0] = u0;
      hand[1] = u1;
      hand[2] = u2;
      while ($urandom_range(99) < idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_full);
      words_sent++;
      decode_word(w);
      if (typed) begin
         for (int i = 0; i < n; i++)
            units_due.insert(units_due.size(),
                             unit_of(hand[i], last && (i == n - 1)));
      end else begin
         foreach (fresh_units[i]) units_due.insert(units_due.size(), fresh_units[i]);
      end
   endtask

   // Lowers push and waits until the decoder has delivered every owed unit.
   task automatic wait_drained();
      req_push <= 1'b0;
      while (units_due.size() != 0) @(posedge clock);
   endtask

   // Builds one random string in str_bytes and sends it, flagging its last byte.
   // Most strings are well formed so the multi-byte paths get exercised; the
   // rest have a corrupted byte, a sequence cut short, or are pure noise.
   task automatic send_random_string();
      int kind;
      int chars;
      int pick;
      kind = $urandom_range(99);
      str_bytes.delete();
      if (kind < 85) begin
         chars = $urandom_range(1, 6);
         for (int c = 0; c < chars; c++) begin
            pick = $urandom_range(2);
            if (pick == 0) begin
               str_bytes.insert(str_bytes.size(), 8'($urandom_range(127)));
            end else if (pick == 1) begin
               str_bytes.insert(str_bytes.size(), 8'hC0 | 8'($urandom_range(31)));
               str_bytes.insert(str_bytes.size(), 8'h80 | 8'($urandom_range(63)));
            end else begin
               str_bytes.insert(str_bytes.size(), 8'hE0 | 8'($urandom_range(15)));
               str_bytes.insert(str_bytes.size(), 8'h80 | 8'($urandom_range(63)));
               str_bytes.insert(str_bytes.size(), 8'h80 | 8'($urandom_range(63)));
            end
         end
         if (kind >= 70) begin
            // Broken: overwrite one byte with anything, then maybe end the
            // string in the middle of a fresh sequence.
            str_bytes[$urandom_range(str_bytes.size() - 1)] = 8'($urandom_range(255));
            pick = $urandom_range(3);
            if (pick == 1) begin
               str_bytes.insert(str_bytes.size(), 8'hC0 | 8'($urandom_range(31)));
            end else if (pick == 2) begin
               str_bytes.insert(str_bytes.size(), 8'hE0 | 8'($urandom_range(15)));
            end else if (pick == 3) begin
               str_bytes.insert(str_bytes.size(), 8'hE0 | 8'($urandom_range(15)));
               str_bytes.insert(str_bytes.size(), 8'($urandom_range(255)));
            end
         end
      end else begin
         chars = $urandom_range(1, 6);
         for (int c = 0; c < chars; c++)
            str_bytes.insert(str_bytes.size(), 8'($urandom_range(255)));
      end
      foreach (str_bytes[i])
         send_word(str_bytes[i], i == str_bytes.size() - 1, 1'b0, 2'd0, '0, '0, '0);
      strings_sent++;
   endtask

   // The receiver pops at random according to the current stall rate.
   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(99) >= stall_pct);
   end

   // Every unit taken from the decoder is compared with the oldest one owed.
   always @(posedge clock) begin
      u8u16_rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (units_due.size() == 0) begin
            report_mismatch("unexpected code unit", rsp_data.code_unit, 16'h0000);
         end else begin
            want = units_due.pop_front();
            units_checked++;
            if (rsp_data.code_unit !== want.code_unit)
               report_mismatch("code_unit", rsp_data.code_unit, want.code_unit);
            if (rsp_data.end_of_run !== want.end_of_run)
               report_mismatch("end_of_run", 16'(rsp_data.end_of_run),
                               16'(want.end_of_run));
         end
      end
   end

   // Main sequence: reset, directed rows, then four random phases.
   initial begin
      int phase_start;
      // Directed strings: plain ASCII extremes, bytes that cannot start a
      // sequence, two- and three-byte sequences at their extremes, a second
      // byte that is not a continuation, a final byte with nothing held, a
      // lead on the final byte, and three-byte sequences cut short by the end
      // of the string with both a non-ASCII and an ASCII tail.
      dir_rows = '{
         '{8'h00, 1'b0, 1'b1, 2'd1, 16'h0000,   16'h0000,   16'h0000},
         '{8'h7F, 1'b0, 1'b1, 2'd1, 16'h007F,   16'h0000,   16'h0000},
         '{8'h80, 1'b0, 1'b1, 2'd1, UNIT_QMARK, 16'h0000,   16'h0000},
         '{8'hF8, 1'b0, 1'b1, 2'd1, UNIT_QMARK, 16'h0000,   16'h0000},
         '{8'hC2, 1'b0, 1'b1, 2'd0, 16'h0000,   16'h0000,   16'h0000},
         '{8'hA9, 1'b0, 1'b0, 2'd0, 16'h0000,   16'h0000,   16'h0000},
         '{8'hDF, 1'b0, 1'b1, 2'd0, 16'h0000,   16'h0000,   16'h0000},
         '{8'hBF, 1'b0, 1'b0, 2'd0, 16'h0000,   16'h0000,   16'h0000},
         '{8'hE2, 1'b0, 1'b1, 2'd0, 16'h0000,   16'h0000,   16'h0000},
         '{8'h82, 1'b0, 1'b1, 2'd0, 16'h0000,   16'h0000,   16'h0000},
         '{8'hAC, 1'b0, 1'b0, 2'd0, 16'h0000,   16'h0000,   16'h0000},
         '{8'hEF, 1'b0, 1'b1, 2'd0, 16'h0000,   16'h0000,   16'h0000},
         '{8'hBF, 1'b0, 1'b1, 2'd0, 16'h0000,   16'h0000,   16'h0000},
         '{8'hBF, 1'b0, 1'b0, 2'd0, 16'h0000,   16'h0000,   16'h0000},
         '{8'hC0, 1'b0, 1'b1, 2'd0, 16'h0000,   16'h0000,   16'h0000},
         '{8'h41, 1'b0, 1'b0, 2'd0, 16'h0000,   16'h0000,   16'h0000},
         '{8'h41, 1'b1, 1'b1, 2'd2, 16'h0041,   UNIT_TERM,  16'h0000},
         '{8'hC3, 1'b1, 1'b1, 2'd2, UNIT_QMARK, UNIT_TERM,  16'h0000},
         '{8'hE4, 1'b0, 1'b1, 2'd0, 16'h0000,   16'h0000,   16'h0000},
         '{8'hB8, 1'b1, 1'b1, 2'd3, UNIT_QMARK, UNIT_QMARK, UNIT_TERM},
         '{8'hE4, 1'b0, 1'b1, 2'd0, 16'h0000,   16'h0000,   16'h0000},
         '{8'h41, 1'b1, 1'b1, 2'd3, UNIT_QMARK, 16'h0041,   UNIT_TERM},
         '{8'hE9, 1'b0, 1'b0, 2'd0, 16'h0000,   16'h0000,   16'h0000},
         '{8'hA6, 1'b0, 1'b0, 2'd0, 16'h0000,   16'h0000,   16'h0000},
         '{8'h99, 1'b1, 1'b0, 2'd0, 16'h0000,   16'h0000,   16'h0000},
         '{8'hFF, 1'b1, 1'b1, 2'd2, UNIT_QMARK, UNIT_TERM,  16'h0000},
         '{8'h00, 1'b1, 1'b1, 2'd2, 16'h0000,   UNIT_TERM,  16'h0000}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i])
         send_word(dir_rows[i].byte_value, dir_rows[i].last, dir_rows[i].typed,
                   dir_rows[i].n, dir_rows[i].u0, dir_rows[i].u1, dir_rows[i].u2);
      strings_sent += 7;

      // Random phases: no idling, sender idling, receiver stalling, then both.
      // At the start of each phase the sender pauses until every owed unit
      // has come out, so the decoder also runs from a drained state.
      for (int phase = 0; phase < 4; phase++) begin
         wait_drained();
         idle_pct  = (phase == 1) ? 46 : (phase == 3) ? 22 : 0;
         stall_pct = (phase == 2) ? 46 : (phase == 3) ? 22 : 0;
         phase_start = words_sent;
         while (words_sent - phase_start < PHASE_WORDS) send_random_string();
      end

      // Let the decoder finish, then keep the clock running so that anything
      // stray can show before the verdict.
      wait_drained();
      repeat (END_SETTLE) @(posedge clock);

      $display("Sent %0d bytes in %0d strings; checked %0d code units.",
               words_sent, strings_sent, units_checked);
      $display("Covered well-formed, corrupted, truncated and noise strings %s",
               "under four idling patterns.");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog: far longer than the slowest correct run can take.
   initial begin
      #2000000;
      $display("Timeout with %0d code units still owed.", units_due.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire

### filelist.f
hw/rtl/u8u16_pkg.sv
hw/rtl/u8u16_front.sv
hw/rtl/u8u16_queue.sv
hw/rtl/u8u16_back.sv
hw/rtl/utf8_to_utf16_bmp_decoder_core.sv
hw/rtl/u8u16_checker.sv
test/testbench.sv
